[sv/vdta_pkg.sv]
// Shared constants for the vector direction angle block: angle accumulator
// format, gain compensation and the CORDIC arctangent table. No dependencies.
`default_nettype none

package vdta_pkg;

  // The angle accumulator counts 2^31 per pi and needs headroom for the
  // pre-rotation plus the sum of all table entries.
  localparam int unsigned ACC_W      = 34;
  localparam int unsigned GUARD_BITS = 16;
  localparam int unsigned GAIN_W     = 31;

  localparam logic signed [ACC_W-1:0] PI_UNITS      = 34'sd2147483648;
  localparam logic signed [ACC_W-1:0] HALF_PI_UNITS = 34'sd1073741824;

  // Gain compensation K = GAIN_COMP / 2^31.
  localparam logic [GAIN_W-1:0] GAIN_COMP = 31'd1304065748;

  // atan(2^-i), counted as 2^31 per pi.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

`default_nettype wire

[sv/vdta_if.sv]
// Channel interfaces of the vector direction angle block: the input vector
// and the four result angles, each with a valid/ready handshake.
`default_nettype none

interface vdta_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

interface vdta_out_if #(
  parameter int ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic        [ANGLE_WIDTH-1:0] polar_angle;
  logic signed [ANGLE_WIDTH-1:0] azimuth_xy;
  logic signed [ANGLE_WIDTH-1:0] angle_zy;
  logic signed [ANGLE_WIDTH-1:0] angle_xz;

  modport source (output valid, output polar_angle, output azimuth_xy,
                  output angle_zy, output angle_xz, input ready);
  modport sink   (input valid, input polar_angle, input azimuth_xy,
                  input angle_zy, input angle_xz, output ready);
endinterface

`default_nettype wire

[sv/vdta_delay.sv]
// Enabled shift register that keeps side data and valid bits aligned with
// the CORDIC stages. No dependencies.
`default_nettype none

module vdta_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  wire  [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

[sv/vdta_cordic.sv]
// Pipelined CORDIC vectoring unit: one pre-rotation stage, then one register
// stage per iteration. Computes atan2(b, a) and the raw final x. Uses vdta_pkg.
`default_nettype none

module vdta_cordic #(
  parameter int DATA_W = 35,
  parameter int STEPS  = 16
) (
  input  wire                                clk_i,
  input  wire                                en_i,
  input  wire  signed [DATA_W-1:0]           a_i,
  input  wire  signed [DATA_W-1:0]           b_i,
  output logic signed [vdta_pkg::ACC_W-1:0]  ang_o,
  output logic signed [DATA_W-1:0]           mag_o,
  output logic                               spec_o,
  output logic        [DATA_W-1:0]           spec_mag_o
);
  import vdta_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [ACC_W-1:0]  acc;
    logic                     spec;
    logic signed [ACC_W-1:0]  spec_ang;
    logic        [DATA_W-1:0] spec_mag;
  } cst_t;

  cst_t st_q [STEPS+1];
  cst_t pre_d;

  logic a_neg, b_neg, a_zero, b_zero;

  // Axis cases are exact and bypass the iterations; otherwise rotate the
  // left half plane into the right one.
  always_comb begin
    a_neg  = a_i[DATA_W-1];
    b_neg  = b_i[DATA_W-1];
    a_zero = (a_i == '0);
    b_zero = (b_i == '0);
    pre_d  = '0;
    pre_d.spec = a_zero || b_zero;
    if (b_zero) begin
      pre_d.spec_ang = a_neg ? PI_UNITS : '0;
      pre_d.spec_mag = a_neg ? -a_i : a_i;
    end else begin
      pre_d.spec_ang = b_neg ? -HALF_PI_UNITS : HALF_PI_UNITS;
      pre_d.spec_mag = b_neg ? -b_i : b_i;
    end
    if (a_neg && !b_neg) begin
      pre_d.a   = b_i;
      pre_d.b   = -a_i;
      pre_d.acc = HALF_PI_UNITS;
    end else if (a_neg) begin
      pre_d.a   = -b_i;
      pre_d.b   = a_i;
      pre_d.acc = -HALF_PI_UNITS;
    end else begin
      pre_d.a   = a_i;
      pre_d.b   = b_i;
      pre_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= pre_d;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cst_t                     nxt;
    logic signed [DATA_W-1:0] da, db;
    always_comb begin
      da  = st_q[i].b >>> i;
      db  = st_q[i].a >>> i;
      nxt = st_q[i];
      if (!st_q[i].b[DATA_W-1]) begin
        nxt.a   = st_q[i].a + da;
        nxt.b   = st_q[i].b - db;
        nxt.acc = st_q[i].acc + $signed(ACC_W'(ATAN_TAB[i]));
      end else begin
        nxt.a   = st_q[i].a - da;
        nxt.b   = st_q[i].b + db;
        nxt.acc = st_q[i].acc - $signed(ACC_W'(ATAN_TAB[i]));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i+1] <= nxt;
    end
  end

  assign ang_o      = st_q[STEPS].spec ? st_q[STEPS].spec_ang : st_q[STEPS].acc;
  assign mag_o      = st_q[STEPS].a;
  assign spec_o     = st_q[STEPS].spec;
  assign spec_mag_o = st_q[STEPS].spec_mag;

endmodule

`default_nettype wire

[sv/vdta_gain.sv]
// Two-stage gain compensation of the CORDIC magnitude: split products in the
// first stage, sum and axis-case select in the second. Uses vdta_pkg.
`default_nettype none

module vdta_gain #(
  parameter int DATA_W = 35
) (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire  signed [DATA_W-1:0]  a_i,
  input  wire                       spec_i,
  input  wire         [DATA_W-1:0]  spec_mag_i,
  output logic signed [DATA_W-1:0]  mag_o
);
  import vdta_pkg::*;

  localparam int HI_W = DATA_W - 31;
  localparam int PW   = HI_W + GAIN_W;
  localparam int LW   = 31 + GAIN_W;
  localparam int SW   = PW + 1;

  logic [DATA_W-1:0] ac;
  logic [PW-1:0]     hi_prod_q;
  logic [LW-1:0]     lo_prod_q;
  logic              spec_q;
  logic [DATA_W-1:0] spec_mag_q;
  logic [SW-1:0]     sum;
  logic [DATA_W-1:0] mag_q;

  assign ac = a_i[DATA_W-1] ? '0 : a_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_prod_q  <= PW'(ac[DATA_W-1:31]) * PW'(GAIN_COMP);
      lo_prod_q  <= LW'(ac[30:0]) * LW'(GAIN_COMP);
      spec_q     <= spec_i;
      spec_mag_q <= spec_mag_i;
    end
  end

  assign sum = SW'(hi_prod_q) + SW'(lo_prod_q[LW-1:31]);

  always_ff @(posedge clk_i) begin
    if (en_i) mag_q <= spec_q ? spec_mag_q : DATA_W'(sum);
  end

  assign mag_o = $signed(mag_q);

endmodule

`default_nettype wire

[sv/vector_to_direction_angles.sv]
// Direction angles of a 3-D vector by pipelined CORDIC vectoring.
// Throughput: one vector per cycle; the whole pipeline advances together and holds
// when the result register is full and not taken.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and the delay lines;
// the CORDIC stage registers are not cleared.
`default_nettype none

module vector_to_direction_angles #(
  parameter int COORD_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  vdta_in_if.sink     vec_i,
  vdta_out_if.source  ang_o
);
  import vdta_pkg::*;

  // Datapath width: guard bits below the coordinate, headroom above it for the
  // CORDIC gain and the pre-rotation. The gain stage needs at least 33 bits.
  localparam int DATA_W = (COORD_WIDTH + 19 < 33) ? 33 : COORD_WIDTH + 19;
  // One pre-rotation stage plus one stage per iteration.
  localparam int CL     = CORDIC_STEPS + 1;
  localparam int SHIFT  = 32 - ANGLE_WIDTH;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'((64'(1) << SHIFT) >> 1);
  localparam logic signed [ACC_W-1:0] TOP      = ACC_W'(64'(1) << (ANGLE_WIDTH - 1));

  // The pipeline moves as one: it advances whenever the result register is
  // empty or being taken, so a stall freezes every stage and loses nothing.
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || ang_o.ready;
  assign vec_i.ready = en;

  logic signed [DATA_W-1:0] xs, ys, zs;
  assign xs = DATA_W'(vec_i.x_coord) <<< GUARD_BITS;
  assign ys = DATA_W'(vec_i.y_coord) <<< GUARD_BITS;
  assign zs = DATA_W'(vec_i.z_coord) <<< GUARD_BITS;

  // First pass: the three plane angles run side by side. Only the x-y unit
  // feeds its magnitude on to the polar angle.
  logic signed [ACC_W-1:0]  phi, chi, psi, theta;
  logic signed [DATA_W-1:0] xy_mag, yz_mag, zx_mag, th_mag;
  logic                     xy_spec, yz_spec, zx_spec, th_spec;
  logic        [DATA_W-1:0] xy_smag, yz_smag, zx_smag, th_smag;

  vdta_cordic #(.DATA_W(DATA_W), .STEPS(CORDIC_STEPS)) u_cordic_xy (
    .clk_i, .en_i(en), .a_i(xs), .b_i(ys), .ang_o(phi), .mag_o(xy_mag),
    .spec_o(xy_spec), .spec_mag_o(xy_smag)
  );
  vdta_cordic #(.DATA_W(DATA_W), .STEPS(CORDIC_STEPS)) u_cordic_yz (
    .clk_i, .en_i(en), .a_i(ys), .b_i(zs), .ang_o(chi), .mag_o(yz_mag),
    .spec_o(yz_spec), .spec_mag_o(yz_smag)
  );
  vdta_cordic #(.DATA_W(DATA_W), .STEPS(CORDIC_STEPS)) u_cordic_zx (
    .clk_i, .en_i(en), .a_i(zs), .b_i(xs), .ang_o(psi), .mag_o(zx_mag),
    .spec_o(zx_spec), .spec_mag_o(zx_smag)
  );

  // Gain compensation turns the x-y magnitude into the cylinder radius r.
  logic signed [DATA_W-1:0] radius;
  vdta_gain #(.DATA_W(DATA_W)) u_gain (
    .clk_i, .en_i(en), .a_i(xy_mag), .spec_i(xy_spec), .spec_mag_i(xy_smag),
    .mag_o(radius)
  );

  // z waits for the radius, then the second pass computes atan2(r, z).
  logic [DATA_W-1:0] z_dly;
  vdta_delay #(.WIDTH(DATA_W), .DEPTH(CL + 2)) u_z_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(zs), .q_o(z_dly)
  );

  vdta_cordic #(.DATA_W(DATA_W), .STEPS(CORDIC_STEPS)) u_cordic_th (
    .clk_i, .en_i(en), .a_i($signed(z_dly)), .b_i(radius), .ang_o(theta),
    .mag_o(th_mag), .spec_o(th_spec), .spec_mag_o(th_smag)
  );

  // The plane angles ride alongside the gain stage and the second pass.
  logic [3*ACC_W-1:0] side_dly;
  vdta_delay #(.WIDTH(3 * ACC_W), .DEPTH(CL + 2)) u_side_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i({phi, chi, psi}), .q_o(side_dly)
  );

  logic vld_last;
  vdta_delay #(.WIDTH(1), .DEPTH(2 * CL + 2)) u_vld_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(vec_i.valid), .q_o(vld_last)
  );

  // Round half up to the output width. The polar angle is clamped into
  // 0 .. pi; the signed angles wrap, so pi reads as -pi.
  logic signed [ACC_W-1:0] r_th, r_phi, r_chi, r_psi;
  logic        [ANGLE_WIDTH-1:0] polar_d;
  assign r_th  = (theta + RND_HALF) >>> SHIFT;
  assign r_phi = ($signed(side_dly[3*ACC_W-1:2*ACC_W]) + RND_HALF) >>> SHIFT;
  assign r_chi = ($signed(side_dly[2*ACC_W-1:ACC_W]) + RND_HALF) >>> SHIFT;
  assign r_psi = ($signed(side_dly[ACC_W-1:0]) + RND_HALF) >>> SHIFT;

  always_comb begin
    if (r_th[ACC_W-1]) begin
      polar_d = '0;
    end else if (r_th > TOP) begin
      polar_d = TOP[ANGLE_WIDTH-1:0];
    end else begin
      polar_d = r_th[ANGLE_WIDTH-1:0];
    end
  end

  logic        [ANGLE_WIDTH-1:0] polar_q;
  logic signed [ANGLE_WIDTH-1:0] phi_q, chi_q, psi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      polar_q <= polar_d;
      phi_q   <= r_phi[ANGLE_WIDTH-1:0];
      chi_q   <= r_chi[ANGLE_WIDTH-1:0];
      psi_q   <= r_psi[ANGLE_WIDTH-1:0];
    end
  end

  assign ang_o.valid       = out_valid_q;
  assign ang_o.polar_angle = polar_q;
  assign ang_o.azimuth_xy  = phi_q;
  assign ang_o.angle_zy    = chi_q;
  assign ang_o.angle_xz    = psi_q;

  // The polar angle never leaves 0 .. pi.
  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ACC_W'(polar_q) <= TOP))
    else $error("polar angle above pi");

  // A stall freezes the pipeline tail.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_last))
    else $error("pipeline moved during a stall");

  // An item at the end of the pipeline lands in the result register.
  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_last |=> out_valid_q)
    else $error("result dropped at the output register");

endmodule

`default_nettype wire

[dv/vdta_angle_checker.sv]
// Checker for the vector direction angle block: watches both channels,
// predicts the four angles of each accepted vector and compares them.
// Depends on vdta_pkg and the channel interfaces in vdta_if.sv.
`timescale 1ns / 100ps
`default_nettype none

module vdta_angle_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  vdta_in_if.sink    vec_mon,
  vdta_out_if.sink   ang_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  import vdta_pkg::*;

  typedef struct packed {
    logic [15:0]        polar;
    logic signed [15:0] azim;
    logic signed [15:0] zy;
    logic signed [15:0] xz;
  } angles_t;

  angles_t angle_queue[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC vectoring of atan2(b, a); angle in 2^31 per pi, gain-corrected radius.
  function automatic void atan2_vec(input longint a_in, input longint b_in,
                                    output longint ang, output longint rad);
    longint a, b, acc, t, da, db, hi, lo;
    a = a_in;
    b = b_in;
    acc = 0;
    if (b == 0) begin
      ang = (a < 0) ? longint'(PI_UNITS) : 0;
      rad = (a < 0) ? -a : a;
      return;
    end
    if (a == 0) begin
      ang = (b > 0) ? longint'(HALF_PI_UNITS) : -longint'(HALF_PI_UNITS);
      rad = (b > 0) ? b : -b;
      return;
    end
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; acc = longint'(HALF_PI_UNITS);
      end else begin
        a = -b; b = t; acc = -longint'(HALF_PI_UNITS);
      end
    end
    for (int i = 0; i < 16; i++) begin
      da = fshift(b, i);
      db = fshift(a, i);
      if (b >= 0) begin
        a += da; b -= db; acc += longint'(ATAN_TAB[i]);
      end else begin
        a -= da; b += db; acc -= longint'(ATAN_TAB[i]);
      end
    end
    ang = acc;
    if (a < 0) a = 0;
    hi = a >>> 31;
    lo = a & 64'h7FFF_FFFF;
    rad = hi * longint'(GAIN_COMP) + ((lo * longint'(GAIN_COMP)) >>> 31);
  endfunction

  function automatic longint round16(longint acc);
    return fshift(acc + 32768, 16);
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] xi,
                                             logic signed [15:0] yi,
                                             logic signed [15:0] zi);
    longint x, y, z, phi, chi, psi, th, r, dummy;
    angles_t res;
    x = longint'(xi) * 65536;
    y = longint'(yi) * 65536;
    z = longint'(zi) * 65536;
    atan2_vec(x, y, phi, r);
    atan2_vec(y, z, chi, dummy);
    atan2_vec(z, x, psi, dummy);
    atan2_vec(z, r, th, dummy);
    th = round16(th);
    if (th < 0) th = 0;
    if (th > 32768) th = 32768;
    res.polar = th[15:0];
    res.azim  = 16'(round16(phi));
    res.zy    = 16'(round16(chi));
    res.xz    = 16'(round16(psi));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = angle_queue.size();

  always @(posedge clk_i) begin
    angles_t exp_a;
    if (rst_ni) begin
      if (vec_mon.valid && vec_mon.ready)
        angle_queue.insert(angle_queue.size(),
                           predict_angles(vec_mon.x_coord, vec_mon.y_coord,
                                          vec_mon.z_coord));
      if (ang_mon.valid && ang_mon.ready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 0);
        end else begin
          exp_a = angle_queue.pop_front();
          checked_o++;
          if (ang_mon.polar_angle !== exp_a.polar)
            report_mismatch("polar_angle", ang_mon.polar_angle, exp_a.polar);
          if (ang_mon.azimuth_xy !== exp_a.azim)
            report_mismatch("azimuth_xy", ang_mon.azimuth_xy, exp_a.azim);
          if (ang_mon.angle_zy !== exp_a.zy)
            report_mismatch("angle_zy", ang_mon.angle_zy, exp_a.zy);
          if (ang_mon.angle_xz !== exp_a.xz)
            report_mismatch("angle_xz", ang_mon.angle_xz, exp_a.xz);
        end
      end
    end
  end

endmodule

`default_nettype wire

[dv/tb_vector_to_direction_angles.sv]
// Testbench top for vector_to_direction_angles: drives vectors with bursts
// and gaps, stalls the result side, and gives the verdict from the checker.
// Depends on vdta_pkg, vdta_if.sv, the block and vdta_angle_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_vector_to_direction_angles;
  import vdta_pkg::*;

  localparam int RANDOM_VECTORS = 1030;
  // The cycle limit leaves ample margin for the whole run with stalls.
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   fail_count, pending, checked;
  int   sent = 0;

  vdta_in_if  vec_ch ();
  vdta_out_if ang_ch ();

  vector_to_direction_angles dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (vec_ch.sink),
    .ang_o  (ang_ch.source)
  );

  vdta_angle_checker angle_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vec_mon      (vec_ch.sink),
    .ang_mon      (ang_ch.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run is cut off here if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver stalls in its own rhythm: one phase always ready, others
  // with random or periodic back-pressure, so stalls land on every pipeline phase.
  always @(posedge clk_i) begin
    case ((cycle_count / 700) % 4)
      0: ang_ch.ready <= 1'b1;
      1: ang_ch.ready <= ($urandom_range(0, 3) != 0);
      2: ang_ch.ready <= (cycle_count % 5) < 2;
      default: ang_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  initial begin
    ang_ch.ready = 1'b0;
    vec_ch.valid = 1'b0;
    vec_ch.x_coord = '0;
    vec_ch.y_coord = '0;
    vec_ch.z_coord = '0;
  end

  // One vector transfer; valid stays high until the block accepts it.
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    vec_ch.valid   <= 1'b1;
    vec_ch.x_coord <= x;
    vec_ch.y_coord <= y;
    vec_ch.z_coord <= z;
    do @(posedge clk_i); while (!vec_ch.ready);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    vec_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has come back.
  // The first edge lets the checker record the last transfer.
  task automatic drain();
    vec_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random component: mostly full range, sometimes small, zero or extreme,
  // so that axis cases and near-pi residues come up often.
  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] edge_vals [6];
    int burst;
    edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh4000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the null vector, each axis both ways, the pi wrap of a
    // negative axis, the polar extremes and full-scale diagonals.
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sh7FFF, 16'sd0, 16'sd0);
    send_vector(16'sh8000, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sh7FFF, 16'sd0);
    send_vector(16'sd0, 16'sh8000, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sh7FFF);
    send_vector(16'sd0, 16'sd0, 16'sh8000);
    send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_vector(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_vector(-16'sd1, 16'sd1, -16'sd1);
    send_vector(16'sd1, -16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1, 16'sh7FFF);
    send_vector(16'sd1, 16'sd1, 16'sh8000);
    for (int i = 0; i < 5; i++)
      send_vector(edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 4) % 6]);

    // Drain completely once before the random part.
    drain();

    while (sent < 20 + RANDOM_VECTORS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++)
        send_vector(rand_coord(), rand_coord(), rand_coord());
      if (sent > 500 && sent < 540) begin
        drain();
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 12));
      end
    end

    drain();
    repeat (50) @(posedge clk_i);

    $display("covered %0d vectors (axes, extremes, random octants); %0d results checked",
             sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[vector_to_direction_angles.f]
sv/vdta_pkg.sv
sv/vdta_if.sv
sv/vdta_delay.sv
sv/vdta_cordic.sv
sv/vdta_gain.sv
sv/vector_to_direction_angles.sv
dv/vdta_angle_checker.sv
dv/tb_vector_to_direction_angles.sv
